@@ rtl/kic_pkg.sv @@
`default_nettype none

package kic_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_WIDTH-1:0]   count_t;

    typedef enum logic [1:0] {
        KEY_DIGIT    = 2'd0,
        KEY_OPERATOR = 2'd1,
        KEY_EQUALS   = 2'd2,
        KEY_CLEAR    = 2'd3
    } key_kind_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    localparam logic [3:0] MAX_DIGIT = 4'd9;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] digit;
        logic [1:0] operator_code;
    } key_t;

    typedef struct packed {
        logic signed [31:0] display_value;
        logic [2:0]         pending_operator;
    } disp_t;

    typedef struct packed {
        logic   start;
        op_t    op;
        value_t a;
        value_t b;
    } alu_req_t;

    typedef struct packed {
        logic   done;
        value_t result;
    } alu_resp_t;

    function automatic logic signed [31:0] to_display(value_t v);
        logic signed [63:0] wide;
        wide = 64'(signed'(v));
        return wide[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/keypad_integer_calculator_unit.sv @@
// Keypad calculator: one key request in, one display request out.
// Key channel (key_valid/key_stall/key): digit, operator, equals or clear.
// Display channel (disp_valid/disp_stall/disp): shown value and pending
// operator, one request per accepted key, in key order.
// Digit, operator and clear keys: the result is registered first, then
// moved into the output register before the next key is taken.
// Equals runs on a shared adder under a small sequencer:
//   add, subtract, no operator: one pass through the adder
//   multiply: shift-add, one bit per cycle
//   divide: two magnitude steps, restoring division one bit per cycle,
//   sign fix; divide by zero skips straight to the finish state
// The next key is taken once the result is in the output register.
// key_stall is high while a key is in work. While disp_stall holds the
// output register full, a finished result waits and no key is taken.
// Reset clears the operands, operator, flags and display to zero and
// empties the output register.
`default_nettype none

module keypad_integer_calculator_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           key_valid,
    output logic                key_stall,
    input  wire kic_pkg::key_t  key,
    output logic                disp_valid,
    input  wire logic           disp_stall,
    output kic_pkg::disp_t      disp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_POST = 3'b100
    } top_state_t;

    top_state_t      state_reg, state_next;
    kic_pkg::value_t first_reg, first_next;
    kic_pkg::value_t second_reg, second_next;
    kic_pkg::value_t shown_reg, shown_next;
    kic_pkg::op_t    pend_reg, pend_next;
    logic            entering_reg, entering_next;
    logic            result_reg, result_next;
    logic            disp_valid_reg, disp_valid_next;
    kic_pkg::disp_t  disp_reg, disp_next;

    kic_pkg::alu_req_t  alu_req;
    kic_pkg::alu_resp_t alu_resp;

    logic            key_fire;
    logic            digit_entering;
    kic_pkg::value_t digit_base;
    kic_pkg::value_t digit_value;

    kic_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req),
        .resp (alu_resp)
    );

    assign key_stall = (state_reg != S_IDLE);
    assign key_fire  = key_valid && !key_stall;

    assign digit_entering = entering_reg && !result_reg;
    assign digit_base     = result_reg ? '0 : (entering_reg ? second_reg : first_reg);
    assign digit_value    = (digit_base << 3) + (digit_base << 1)
                          + kic_pkg::value_t'(key.digit);

    assign alu_req.start = key_fire && (key.cmd == kic_pkg::KEY_EQUALS);
    assign alu_req.op    = pend_reg;
    assign alu_req.a     = first_reg;
    assign alu_req.b     = second_reg;

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        shown_next      = shown_reg;
        pend_next       = pend_reg;
        entering_next   = entering_reg;
        result_next     = result_reg;
        disp_valid_next = disp_valid_reg && disp_stall;
        disp_next       = disp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (key_fire)
                begin
                    state_next = S_POST;
                    case (key.cmd)
                        kic_pkg::KEY_DIGIT:
                        begin
                            if (key.digit <= kic_pkg::MAX_DIGIT)
                            begin
                                if (result_reg)
                                begin
                                    pend_next   = kic_pkg::OP_NONE;
                                    result_next = 1'b0;
                                end
                                entering_next = digit_entering;
                                if (digit_entering)
                                begin
                                    second_next = digit_value;
                                end
                                else
                                begin
                                    first_next  = digit_value;
                                    second_next = result_reg ? '0 : second_reg;
                                end
                                shown_next = digit_value;
                            end
                        end
                        kic_pkg::KEY_OPERATOR:
                        begin
                            pend_next     = kic_pkg::op_t'(3'(key.operator_code) + 3'd1);
                            entering_next = 1'b1;
                            second_next   = '0;
                            result_next   = 1'b0;
                        end
                        kic_pkg::KEY_EQUALS:
                        begin
                            state_next = S_CALC;
                        end
                        default:
                        begin
                            first_next    = '0;
                            second_next   = '0;
                            shown_next    = '0;
                            pend_next     = kic_pkg::OP_NONE;
                            entering_next = 1'b0;
                            result_next   = 1'b0;
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                if (alu_resp.done)
                begin
                    first_next    = alu_resp.result;
                    shown_next    = alu_resp.result;
                    result_next   = 1'b1;
                    entering_next = 1'b0;
                    state_next    = S_POST;
                end
            end
            S_POST:
            begin
                if (!disp_valid_reg || !disp_stall)
                begin
                    disp_valid_next            = 1'b1;
                    disp_next.display_value    = kic_pkg::to_display(shown_reg);
                    disp_next.pending_operator = pend_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_reg      <= '0;
            second_reg     <= '0;
            shown_reg      <= '0;
            pend_reg       <= kic_pkg::OP_NONE;
            entering_reg   <= 1'b0;
            result_reg     <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            shown_reg      <= shown_next;
            pend_reg       <= pend_next;
            entering_reg   <= entering_next;
            result_reg     <= result_next;
            disp_valid_reg <= disp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        disp_reg <= disp_next;
    end

    assign disp_valid = disp_valid_reg;
    assign disp       = disp_reg;

endmodule

`default_nettype wire

@@ rtl/kic_alu.sv @@
`default_nettype none

module kic_alu (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kic_pkg::alu_req_t   req,
    output kic_pkg::alu_resp_t       resp
);

    typedef enum logic [7:0] {
        A_IDLE = 8'b0000_0001,
        A_ADD  = 8'b0000_0010,
        A_MUL  = 8'b0000_0100,
        A_ABSA = 8'b0000_1000,
        A_ABSB = 8'b0001_0000,
        A_DIV  = 8'b0010_0000,
        A_NEG  = 8'b0100_0000,
        A_FIN  = 8'b1000_0000
    } alu_state_t;

    typedef logic [kic_pkg::VALUE_WIDTH:0]   operand_t;
    typedef logic [kic_pkg::VALUE_WIDTH+1:0] sum_t;

    alu_state_t      state_reg, state_next;
    kic_pkg::value_t acc_reg, acc_next;
    kic_pkg::value_t x_reg, x_next;
    kic_pkg::value_t y_reg, y_next;
    kic_pkg::count_t cnt_reg, cnt_next;
    kic_pkg::op_t    op_reg, op_next;
    logic            neg_reg, neg_next;

    operand_t add_x, add_y;
    logic     add_cin;
    sum_t     sum;
    logic     x_msb;
    logic     y_msb;

    assign x_msb = x_reg[kic_pkg::VALUE_WIDTH-1];
    assign y_msb = y_reg[kic_pkg::VALUE_WIDTH-1];

    // single shared adder
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            A_ADD:
            begin
                add_x = operand_t'(x_reg);
                if (op_reg == kic_pkg::OP_SUB)
                begin
                    add_y   = ~operand_t'(y_reg);
                    add_cin = 1'b1;
                end
                else if (op_reg == kic_pkg::OP_ADD)
                begin
                    add_y = operand_t'(y_reg);
                end
            end
            A_MUL:
            begin
                add_x = operand_t'(acc_reg);
                add_y = y_reg[0] ? operand_t'(x_reg) : '0;
            end
            A_ABSA:
            begin
                add_y   = x_msb ? ~operand_t'(x_reg) : operand_t'(x_reg);
                add_cin = x_msb;
            end
            A_ABSB:
            begin
                add_y   = y_msb ? ~operand_t'(y_reg) : operand_t'(y_reg);
                add_cin = y_msb;
            end
            A_DIV:
            begin
                add_x   = {acc_reg, x_msb};
                add_y   = ~operand_t'(y_reg);
                add_cin = 1'b1;
            end
            A_NEG:
            begin
                add_y   = neg_reg ? ~operand_t'(x_reg) : operand_t'(x_reg);
                add_cin = neg_reg;
            end
            A_IDLE, A_FIN:
            begin
            end
            default:
            begin
            end
        endcase
        sum = sum_t'(add_x) + sum_t'(add_y) + sum_t'(add_cin);
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    x_next   = req.a;
                    y_next   = req.b;
                    acc_next = '0;
                    op_next  = req.op;
                    cnt_next = kic_pkg::count_t'(kic_pkg::VALUE_WIDTH);
                    neg_next = req.a[kic_pkg::VALUE_WIDTH-1] ^ req.b[kic_pkg::VALUE_WIDTH-1];
                    case (req.op)
                        kic_pkg::OP_MUL:
                        begin
                            state_next = A_MUL;
                        end
                        kic_pkg::OP_DIV:
                        begin
                            if (req.b == '0)
                            begin
                                acc_next   = req.a;
                                state_next = A_FIN;
                            end
                            else
                            begin
                                state_next = A_ABSA;
                            end
                        end
                        default:
                        begin
                            state_next = A_ADD;
                        end
                    endcase
                end
            end
            A_ADD:
            begin
                acc_next   = sum[kic_pkg::VALUE_WIDTH-1:0];
                state_next = A_FIN;
            end
            A_MUL:
            begin
                acc_next = sum[kic_pkg::VALUE_WIDTH-1:0];
                x_next   = {x_reg[kic_pkg::VALUE_WIDTH-2:0], 1'b0};
                y_next   = {1'b0, y_reg[kic_pkg::VALUE_WIDTH-1:1]};
                cnt_next = cnt_reg - kic_pkg::count_t'(1);
                if (cnt_reg == kic_pkg::count_t'(1))
                begin
                    state_next = A_FIN;
                end
            end
            A_ABSA:
            begin
                x_next     = sum[kic_pkg::VALUE_WIDTH-1:0];
                state_next = A_ABSB;
            end
            A_ABSB:
            begin
                y_next     = sum[kic_pkg::VALUE_WIDTH-1:0];
                state_next = A_DIV;
            end
            A_DIV:
            begin
                // carry out set: trial subtract did not borrow
                if (sum[kic_pkg::VALUE_WIDTH+1])
                begin
                    acc_next = sum[kic_pkg::VALUE_WIDTH-1:0];
                    x_next   = {x_reg[kic_pkg::VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[kic_pkg::VALUE_WIDTH-2:0], x_msb};
                    x_next   = {x_reg[kic_pkg::VALUE_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - kic_pkg::count_t'(1);
                if (cnt_reg == kic_pkg::count_t'(1))
                begin
                    state_next = A_NEG;
                end
            end
            A_NEG:
            begin
                acc_next   = sum[kic_pkg::VALUE_WIDTH-1:0];
                state_next = A_FIN;
            end
            A_FIN:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        neg_reg <= neg_next;
    end

    assign resp.done   = (state_reg == A_FIN);
    assign resp.result = acc_reg;

endmodule

`default_nettype wire

@@ tb/keypad_integer_calculator_unit_tb.sv @@
`default_nettype none

module keypad_integer_calculator_unit_tb;

    localparam int              CLK_PERIOD     = 10;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              KEYS_PER_PHASE = 480;
    localparam kic_pkg::value_t DECIMAL_BASE   = kic_pkg::value_t'(10);

    localparam logic [1:0] OPC_ADD = 2'd0;
    localparam logic [1:0] OPC_SUB = 2'd1;
    localparam logic [1:0] OPC_MUL = 2'd2;
    localparam logic [1:0] OPC_DIV = 2'd3;

    class calc_scoreboard;
        kic_pkg::value_t first_opd;
        kic_pkg::value_t second_opd;
        kic_pkg::value_t shown;
        kic_pkg::op_t    pend_op;
        bit              entering_second;
        bit              result_shown;
        kic_pkg::disp_t  display_q[$];
        int              errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            first_opd       = '0;
            second_opd      = '0;
            shown           = '0;
            pend_op         = kic_pkg::OP_NONE;
            entering_second = 1'b0;
            result_shown    = 1'b0;
        endfunction

        function kic_pkg::value_t calc_result();
            kic_pkg::value_t mag_a;
            kic_pkg::value_t mag_b;
            kic_pkg::value_t quo;
            case (pend_op)
                kic_pkg::OP_ADD: return first_opd + second_opd;
                kic_pkg::OP_SUB: return first_opd - second_opd;
                kic_pkg::OP_MUL: return first_opd * second_opd;
                kic_pkg::OP_DIV:
                begin
                    if (second_opd == '0)
                        return first_opd;
                    mag_a = first_opd[kic_pkg::VALUE_WIDTH-1] ? -first_opd : first_opd;
                    mag_b = second_opd[kic_pkg::VALUE_WIDTH-1] ? -second_opd : second_opd;
                    quo   = mag_a / mag_b;
                    if (first_opd[kic_pkg::VALUE_WIDTH-1] != second_opd[kic_pkg::VALUE_WIDTH-1])
                        quo = -quo;
                    return quo;
                end
                default: return first_opd;
            endcase
        endfunction

        function void note_key(kic_pkg::key_t k);
            kic_pkg::disp_t d;
            case (k.cmd)
                kic_pkg::KEY_DIGIT:
                begin
                    if (k.digit <= kic_pkg::MAX_DIGIT)
                    begin
                        if (result_shown)
                        begin
                            first_opd       = '0;
                            second_opd      = '0;
                            pend_op         = kic_pkg::OP_NONE;
                            result_shown    = 1'b0;
                            entering_second = 1'b0;
                        end
                        if (!entering_second)
                        begin
                            first_opd = first_opd * DECIMAL_BASE + k.digit;
                            shown     = first_opd;
                        end
                        else
                        begin
                            second_opd = second_opd * DECIMAL_BASE + k.digit;
                            shown      = second_opd;
                        end
                    end
                end
                kic_pkg::KEY_OPERATOR:
                begin
                    pend_op         = kic_pkg::op_t'({1'b0, k.operator_code} + 3'd1);
                    entering_second = 1'b1;
                    second_opd      = '0;
                    result_shown    = 1'b0;
                end
                kic_pkg::KEY_EQUALS:
                begin
                    shown           = calc_result();
                    first_opd       = shown;
                    result_shown    = 1'b1;
                    entering_second = 1'b0;
                end
                default: clear_state();
            endcase
            d.display_value    = 32'(signed'(shown));
            d.pending_operator = pend_op;
            display_q.push_back(d);
        endfunction

        function void check_disp(kic_pkg::disp_t got);
            kic_pkg::disp_t want;
            if (display_q.size() == 0)
            begin
                errors++;
                $display("%0t: display request expected none got value %0d operator %0d",
                         $time, got.display_value, got.pending_operator);
                return;
            end
            want = display_q.pop_front();
            if (got.display_value !== want.display_value)
            begin
                errors++;
                $display("%0t: display_value expected %0d got %0d",
                         $time, want.display_value, got.display_value);
            end
            if (got.pending_operator !== want.pending_operator)
            begin
                errors++;
                $display("%0t: pending_operator expected %0d got %0d",
                         $time, want.pending_operator, got.pending_operator);
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           key_valid;
    logic           key_stall;
    kic_pkg::key_t  key;
    logic           disp_valid;
    logic           disp_stall;
    kic_pkg::disp_t disp;

    calc_scoreboard sb = new;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             keys_sent     = 0;
    int             idle_cycles   = 0;

    keypad_integer_calculator_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key        (key),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp       (disp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        disp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (key_valid && !key_stall)
                sb.note_key(key);
            if (disp_valid && !disp_stall)
                sb.check_disp(disp);
            if ((key_valid && !key_stall) || (disp_valid && !disp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic kic_pkg::key_t make_key(logic [1:0] cmd, logic [3:0] dig,
                                               logic [1:0] opc);
        kic_pkg::key_t k;
        k.cmd           = cmd;
        k.digit         = dig;
        k.operator_code = opc;
        return k;
    endfunction

    // holds the request until taken, then maybe goes idle for a while
    task automatic send_key(input kic_pkg::key_t k);
        key_valid <= 1'b1;
        key       <= k;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        keys_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            key_valid <= 1'b0;
            key       <= kic_pkg::key_t'($urandom_range(255));
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic type_number(input string s);
        for (int i = 0; i < s.len(); i++)
            send_key(make_key(kic_pkg::KEY_DIGIT, 4'(s.getc(i) - "0"), OPC_ADD));
    endtask

    task automatic type_digits();
        int len;
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            len = $urandom_range(3, 1);
        else if (roll < 90)
            len = $urandom_range(6, 4);
        else
            len = $urandom_range(11, 7);
        repeat (len)
            send_key(make_key(kic_pkg::KEY_DIGIT, 4'($urandom_range(9)), 2'($urandom)));
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        send_key(make_key(cmd, 4'($urandom), 2'($urandom)));
    endtask

    // operand, operator, operand, equals; sometimes chained or repeated
    task automatic random_formula();
        if ($urandom_range(3) == 0)
            send_cmd(kic_pkg::KEY_CLEAR);
        if ($urandom_range(2) != 0)
            type_digits();
        send_cmd(kic_pkg::KEY_OPERATOR);
        if ($urandom_range(9) != 0)
            type_digits();
        send_cmd(kic_pkg::KEY_EQUALS);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(2, 1))
                send_cmd(kic_pkg::KEY_EQUALS);
        if ($urandom_range(4) == 0)
            type_digits();
    endtask

    initial
    begin
        int phase_end;
        rst_n     <= 1'b0;
        key_valid <= 1'b0;
        key       <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_key(make_key(kic_pkg::KEY_DIGIT, 4'd15, OPC_MUL));
        send_key(make_key(kic_pkg::KEY_EQUALS, 4'd0, OPC_ADD));
        type_number("2147483648");
        send_key(make_key(kic_pkg::KEY_OPERATOR, 4'd0, OPC_DIV));
        type_number("4294967295");
        send_key(make_key(kic_pkg::KEY_EQUALS, 4'd0, OPC_ADD));
        send_key(make_key(kic_pkg::KEY_EQUALS, 4'd9, OPC_SUB));
        send_key(make_key(kic_pkg::KEY_CLEAR, 4'd7, OPC_DIV));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 67;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            phase_end = keys_sent + KEYS_PER_PHASE;
            while (keys_sent < phase_end)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(4, 1))
                        send_key(kic_pkg::key_t'($urandom_range(255)));
                else
                    random_formula();
            end
        end

        key_valid     <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        do
            @(posedge clk);
        while (sb.display_q.size() != 0);
        repeat (2 * kic_pkg::VALUE_WIDTH)
            @(posedge clk);
        @(negedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/kic_pkg.sv
rtl/kic_alu.sv
rtl/keypad_integer_calculator_unit.sv
tb/keypad_integer_calculator_unit_tb.sv
